@@ sv/esc_pkg.sv @@
// Package for the environmental sensor compensation block: widths, register
// indexes and small helpers shared by the pipeline modules. No dependencies.
package esc_pkg;

    localparam int RAW_T_W    = 20;
    localparam int RAW_P_W    = 20;
    localparam int RAW_H_W    = 16;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 88;
    localparam int QUO_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CALIB    = 3'd0,
        REG_PRESS_CALIB_A = 3'd1,
        REG_PRESS_CALIB_B = 3'd2,
        REG_PRESS_CALIB_C = 3'd3,
        REG_HUM_CALIB_A   = 3'd4,
        REG_HUM_CALIB_B   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] temp_calib;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [39:0] hum_a;
        logic [23:0] hum_b;
    } calib_t;

    // Results that travel from the compute pipeline to the output stage
    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] pressure_centi_pa;
        logic               pressure_valid;
        logic [16:0]        humidity_q10;
    } result_t;

endpackage

@@ sv/esc_div.sv @@
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on esc_pkg. Tags and side payload travel alongside each stage.
module esc_div
    import esc_pkg::*;
#(
    parameter int SIDE_W = 8
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [63:0]           num,
    input  logic [63:0]           den,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [63:0]           quo,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int N = QUO_W;

    logic [N:0]       vld_reg;
    logic [63:0]      rem_reg  [N+1];
    logic [63:0]      q_reg    [N+1];
    logic [63:0]      d_reg    [N+1];
    logic             neg_reg  [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];

    logic [63:0] mn;
    logic [63:0] md;

    // Take magnitudes at entry
    always_comb
    begin
        mn = num[63] ? (64'd0 - num) : num;
        md = den[63] ? (64'd0 - den) : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            q_reg[0]    <= mn;
            d_reg[0]    <= md;
            neg_reg[0]  <= num[63] ^ den[63];
            side_reg[0] <= in_side;
        end
    end

    // One restoring step per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic [64:0] r_sh;
        logic [64:0] diff;
        always_comb
        begin
            r_sh = {rem_reg[i], q_reg[i][63]};
            diff = r_sh - {1'b0, d_reg[i]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[64])
                begin
                    rem_reg[i+1] <= diff[63:0];
                    q_reg[i+1]   <= {q_reg[i][62:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= r_sh[63:0];
                    q_reg[i+1]   <= {q_reg[i][62:0], 1'b0};
                end
                d_reg[i+1]    <= d_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign quo       = neg_reg[N] ? (64'd0 - q_reg[N]) : q_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ sv/esc_core.sv @@
// Compensation datapath: fine temperature, humidity, pressure front end,
// divider and pressure back end, all pipelined. Depends on esc_pkg, esc_div.
module esc_core
    import esc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAW_T_W-1:0]   raw_temperature,
    input  logic [RAW_P_W-1:0]   raw_pressure,
    input  logic [RAW_H_W-1:0]   raw_humidity,
    input  calib_t               cal,
    output logic                 out_valid,
    output result_t              res
);

    // ---------------- stage 1: temperature products
    logic [31:0] ta_reg, tbb_reg, t3_reg;
    logic [31:0] t2_reg;
    logic [19:0] rp1_reg;
    logic [15:0] rh1_reg;

    logic [31:0] a_c, b_c, t1_c;
    always_comb
    begin
        t1_c = {16'd0, cal.temp_calib[15:0]};
        a_c  = {15'd0, raw_temperature[19:3]} - (t1_c << 1);
        b_c  = {16'd0, raw_temperature[19:4]} - t1_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg  <= a_c;
            tbb_reg <= b_c * b_c;
            t2_reg  <= {{16{cal.temp_calib[31]}}, cal.temp_calib[31:16]};
            t3_reg  <= {{16{cal.temp_calib[47]}}, cal.temp_calib[47:32]};
            rp1_reg <= raw_pressure;
            rh1_reg <= raw_humidity;
        end
    end

    // ---------------- stage 2: second products
    logic [31:0] v1p_reg, v2p_reg;
    logic [19:0] rp2_reg;
    logic [15:0] rh2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1p_reg <= ta_reg * t2_reg;
            v2p_reg <= $unsigned($signed(tbb_reg) >>> 12) * t3_reg;
            rp2_reg <= rp1_reg;
            rh2_reg <= rh1_reg;
        end
    end

    // ---------------- stage 3: fine temperature
    logic [31:0] tf_reg;
    logic [19:0] rp3_reg;
    logic [15:0] rh3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tf_reg  <= $unsigned($signed(v1p_reg) >>> 11)
                     + $unsigned($signed(v2p_reg) >>> 14);
            rp3_reg <= rp2_reg;
            rh3_reg <= rh2_reg;
        end
    end

    // ---------------- stage 4: first products of humidity and pressure
    logic [31:0] temp4_reg;
    logic [31:0] h5hx_reg, h6hx_reg, h3hx_reg;
    logic [63:0] xx_reg, xp5_reg, xp2_reg;
    logic [19:0] rp4_reg;
    logic [15:0] rh4_reg;

    logic [31:0] hx_c, h5_c, h6_c, h3_c;
    logic signed [32:0] xs_c;
    always_comb
    begin
        hx_c = tf_reg - 32'd76800;
        h5_c = {{20{cal.hum_b[23]}}, cal.hum_b[23:12]};
        h6_c = {{24{cal.hum_a[39]}}, cal.hum_a[39:32]};
        h3_c = {24'd0, cal.hum_a[31:24]};
        xs_c = $signed({tf_reg[31], tf_reg}) - 33'sd128000;
    end

    // x is a 33-bit signed value; its products are formed at that width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp4_reg <= $unsigned($signed(tf_reg * 32'd5 + 32'd128) >>> 8);
            h5hx_reg  <= h5_c * hx_c;
            h6hx_reg  <= hx_c * h6_c;
            h3hx_reg  <= hx_c * h3_c;
            xx_reg    <= 64'(xs_c * xs_c);
            xp5_reg   <= 64'(xs_c * $signed(cal.press_b[31:16]));
            xp2_reg   <= 64'(xs_c * $signed(cal.press_a[31:16]));
            rp4_reg   <= rp3_reg;
            rh4_reg   <= rh3_reg;
        end
    end

    // ---------------- stage 5
    logic [31:0] temp5_reg, term1_reg, inner_reg;
    logic [63:0] w2a_reg, xxp3_reg, xp5s_reg, xp2s_reg;
    logic [19:0] rp5_reg;
    logic [31:0] h4_c, t1a_c;
    logic [63:0] p6_c, p3_c;
    always_comb
    begin
        h4_c  = {{20{cal.hum_b[11]}}, cal.hum_b[11:0]};
        t1a_c = ({16'd0, rh4_reg} << 14) - (h4_c << 20) - h5hx_reg + 32'd16384;
        p6_c  = {{48{cal.press_b[47]}}, cal.press_b[47:32]};
        p3_c  = {{48{cal.press_a[47]}}, cal.press_a[47:32]};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp5_reg <= temp4_reg;
            term1_reg <= $unsigned($signed(t1a_c) >>> 15);
            inner_reg <= $unsigned($signed(h6hx_reg) >>> 10)
                       * ($unsigned($signed(h3hx_reg) >>> 11) + 32'd32768);
            w2a_reg   <= xx_reg * p6_c;
            xxp3_reg  <= xx_reg * p3_c;
            xp5s_reg  <= xp5_reg << 17;
            xp2s_reg  <= xp2_reg << 12;
            rp5_reg   <= rp4_reg;
        end
    end

    // ---------------- stage 6
    logic [31:0] temp6_reg, term16_reg, h2i_reg;
    logic [63:0] w2_reg, w1a_reg;
    logic [19:0] rp6_reg;
    logic [31:0] inner_c, h2_c;
    logic [63:0] p4_c;
    always_comb
    begin
        inner_c = $unsigned($signed(inner_reg) >>> 10) + 32'd2097152;
        h2_c    = {{16{cal.hum_a[23]}}, cal.hum_a[23:8]};
        p4_c    = {{48{cal.press_b[15]}}, cal.press_b[15:0]};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp6_reg  <= temp5_reg;
            term16_reg <= term1_reg;
            h2i_reg    <= inner_c * h2_c;
            w2_reg     <= w2a_reg + xp5s_reg + (p4_c << 35);
            w1a_reg    <= 64'h0000_8000_0000_0000
                        + $unsigned($signed(xxp3_reg) >>> 8) + xp2s_reg;
            rp6_reg    <= rp5_reg;
        end
    end

    // ---------------- stage 7: humidity product, pressure w1 and numerator
    logic [31:0] temp7_reg, hv_reg;
    logic [63:0] w1p_reg, num_reg;
    logic [63:0] pn_c;
    always_comb
    begin
        pn_c = ((({44'd0, 20'd0} + 64'd1048576 - {44'd0, rp6_reg}) << 31) - w2_reg);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp7_reg <= temp6_reg;
            hv_reg    <= term16_reg
                       * $unsigned($signed(h2i_reg + 32'd8192) >>> 14);
            w1p_reg   <= w1a_reg * {48'd0, cal.press_a[15:0]};
            num_reg   <= pn_c * 64'd3125;
        end
    end

    // ---------------- stage 8: humidity square, divisor
    logic [31:0] temp8_reg, hv8_reg, ss_reg;
    logic [63:0] w1_reg, num8_reg;
    logic [31:0] s_c;
    always_comb
    begin
        s_c = $unsigned($signed(hv_reg) >>> 15);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp8_reg <= temp7_reg;
            hv8_reg   <= hv_reg;
            ss_reg    <= s_c * s_c;
            w1_reg    <= $unsigned($signed(w1p_reg) >>> 33);
            num8_reg  <= num_reg;
        end
    end

    // ---------------- stage 9: humidity clamp; divider operands held alongside
    logic [31:0] temp9_reg;
    logic [16:0] hum9_reg;
    logic [63:0] w1_9_reg, num9_reg;
    logic [31:0] hd_c;
    always_comb
    begin
        hd_c = hv8_reg - $unsigned($signed($unsigned($signed(ss_reg) >>> 7)
             * {24'd0, cal.hum_a[7:0]}) >>> 4);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp9_reg <= temp8_reg;
            w1_9_reg  <= w1_reg;
            num9_reg  <= num8_reg;
            if (hd_c[31])
                hum9_reg <= '0;
            else if (hd_c > 32'd419430400)
                hum9_reg <= 17'(32'd419430400 >> 12);
            else
                hum9_reg <= hd_c[28:12];
        end
    end

    // valid shift line for the front stages
    logic [8:0] vf_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= '0;
        else if (en)
            vf_reg <= {vf_reg[7:0], in_valid};
    end

    // ---------------- divider; temperature, humidity and zero flag ride along
    localparam int SIDE_W = 32 + 17 + 1;
    logic              dv_valid;
    logic [63:0]       dq;
    logic [SIDE_W-1:0] dside;
    logic              nz_c;
    assign nz_c = (w1_9_reg != 64'd0);

    esc_div #(.SIDE_W(SIDE_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vf_reg[8]),
        .num       (num9_reg),
        .den       (nz_c ? w1_9_reg : 64'd1),
        .in_side   ({temp9_reg, hum9_reg, nz_c}),
        .out_valid (dv_valid),
        .quo       (dq),
        .out_side  (dside)
    );

    // ---------------- back end stage A: products with p9 and p8
    logic [63:0] pA_reg, qa_reg, qq_reg, p8p_reg;
    logic [SIDE_W-1:0] sA_reg;
    logic        vA_reg, vB_reg, vB2_reg, vC_reg, vD_reg;
    logic [63:0] q_c, p8_c, p9_c, p7_c;
    always_comb
    begin
        q_c  = $unsigned($signed(dq) >>> 13);
        p8_c = {{48{cal.press_c[31]}}, cal.press_c[31:16]};
        p9_c = {{48{cal.press_c[47]}}, cal.press_c[47:32]};
        p7_c = {{48{cal.press_c[15]}}, cal.press_c[15:0]};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pA_reg  <= dq;
            qa_reg  <= q_c;
            qq_reg  <= p9_c * q_c;
            p8p_reg <= p8_c * dq;
            sA_reg  <= dside;
        end
    end

    // ---------------- back end stage B: 32-bit partial products of p9*q*q
    logic [63:0] pB_reg, u1ll_reg, u2_reg;
    logic [31:0] u1hl_reg, u1lh_reg;
    logic [SIDE_W-1:0] sB_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pB_reg   <= pA_reg;
            u1ll_reg <= {32'd0, qq_reg[31:0]} * {32'd0, qa_reg[31:0]};
            u1hl_reg <= qq_reg[63:32] * qa_reg[31:0];
            u1lh_reg <= qq_reg[31:0] * qa_reg[63:32];
            u2_reg   <= $unsigned($signed(p8p_reg) >>> 19);
            sB_reg   <= sA_reg;
        end
    end

    // ---------------- back end stage B2: combine the partial products
    logic [63:0] pB2_reg, u1_reg, u2b_reg;
    logic [SIDE_W-1:0] sB2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pB2_reg <= pB_reg;
            u1_reg  <= u1ll_reg + {u1hl_reg + u1lh_reg, 32'd0};
            u2b_reg <= u2_reg;
            sB2_reg <= sB_reg;
        end
    end

    // ---------------- back end stage C
    logic [63:0] pC_reg;
    logic [SIDE_W-1:0] sC_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pC_reg <= $unsigned($signed(pB2_reg + $unsigned($signed(u1_reg) >>> 25)
                    + u2b_reg) >>> 8) + (p7_c << 4);
            sC_reg <= sB2_reg;
        end
    end

    // ---------------- back end stage D: scale to pascals times 100
    logic [31:0] press_reg;
    logic [SIDE_W-1:0] sD_reg;
    logic [63:0] ps_c;
    always_comb
    begin
        ps_c = $unsigned($signed(pC_reg) >>> 8);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            press_reg <= ps_c[31:0] * 32'd100;
            sD_reg    <= sC_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vA_reg  <= 1'b0;
            vB_reg  <= 1'b0;
            vB2_reg <= 1'b0;
            vC_reg  <= 1'b0;
            vD_reg  <= 1'b0;
        end
        else if (en)
        begin
            vA_reg  <= dv_valid;
            vB_reg  <= vA_reg;
            vB2_reg <= vB_reg;
            vC_reg  <= vB2_reg;
            vD_reg  <= vC_reg;
        end
    end

    assign out_valid             = vD_reg;
    assign res.temperature_centi = $signed(sD_reg[SIDE_W-1 -: 32]);
    assign res.humidity_q10      = sD_reg[17:1];
    assign res.pressure_valid    = sD_reg[0];
    assign res.pressure_centi_pa = sD_reg[0] ? $signed(press_reg) : 32'sd0;

endmodule

@@ sv/esc_cfg.sv @@
// Calibration register file written through the plain configuration port.
// Depends on esc_pkg.
module esc_cfg
    import esc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output calib_t                cal
);

    calib_t cal_reg;

    // Latch the addressed word, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP_CALIB:    cal_reg.temp_calib <= cfg_data;
                REG_PRESS_CALIB_A: cal_reg.press_a    <= cfg_data;
                REG_PRESS_CALIB_B: cal_reg.press_b    <= cfg_data;
                REG_PRESS_CALIB_C: cal_reg.press_c    <= cfg_data;
                REG_HUM_CALIB_A:   cal_reg.hum_a      <= cfg_data[39:0];
                REG_HUM_CALIB_B:   cal_reg.hum_b      <= cfg_data[23:0];
                default:           cal_reg            <= cal_reg;
            endcase
        end
    end

    assign cal = cal_reg;

endmodule

@@ sv/env_sensor_compensation.sv @@
// Environmental sensor compensation, top level.
// Pipeline: 80 register stages (9 datapath stages, 65 divider stages, 5 pressure
// back-end stages, output register). The pipeline advances whenever the output
// register is free, so one reading per cycle is sustained unless the output is
// stalled by m_tready.
// Reset: rst_n asynchronous, active low; clears valid bits and calibration.
// Depends on esc_pkg, esc_cfg, esc_core, esc_div.
module env_sensor_compensation
    import esc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // temperature_centi[31:0], pressure_centi_pa[63:32], pressure_valid[64],
    // humidity_q10[81:65], zero fill [87:82]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    calib_t  cal;
    logic    en;
    logic    core_valid;
    result_t res;

    esc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // Advance the whole pipeline while the output register can take a result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    esc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_tvalid),
        .raw_temperature (s_tdata[19:0]),
        .raw_pressure    (s_tdata[39:20]),
        .raw_humidity    (s_tdata[55:40]),
        .cal             (cal),
        .out_valid       (core_valid),
        .res             (res)
    );

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (en)
            m_tvalid_reg <= core_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            m_tdata_reg <= {6'd0, res.humidity_q10, res.pressure_valid,
                            res.pressure_centi_pa, res.temperature_centi};
    end
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // A stalled output holds the pipeline still
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken during output stall");

    // Humidity never exceeds the clamp
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[81:65] <= 17'd102400))
        else $error("humidity out of range");

    // Invalid pressure reads as zero
    a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[64]) |-> (m_tdata[63:32] == 32'd0))
        else $error("pressure nonzero while flagged invalid");
`endif

endmodule
